@@ hw/rtl/shared_exclusive_lock_table_defines.svh @@
// ----------------------------------------------------------------------------
// Shared/exclusive lock table assertion macros
// Property wrappers with common clocking and reset for the lock table checks.
// ----------------------------------------------------------------------------
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_DEFINES_SVH

// Overlapping implication; the consequent may start with a ## delay operator.
`define SXLT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication.
`define SXLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sxlt_pkg.sv @@
// ----------------------------------------------------------------------------
// Lock table package
// Sizes, entry layout, command and status codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sxlt_pkg;

  localparam int NUM_RESOURCES = 64;
  localparam int NUM_TXNS      = 16;

  localparam int CMD_W      = 2;
  localparam int TXN_W      = 4;
  localparam int RESOURCE_W = 6;
  localparam int STATUS_W   = 2;

  localparam int RES_W = $clog2(NUM_RESOURCES);

  typedef struct packed {
    logic [NUM_TXNS-1:0] sh_bits;
    logic                excl_valid;
    logic [TXN_W-1:0]    excl_owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [CMD_W-1:0] {
    CMD_SHARED  = 2'd0,
    CMD_EXCL    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_WAIT     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_NOTHING  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOCK,
    S_SWEEP,
    S_HOLD
  } state_t;

  function automatic logic txn_ok(logic [TXN_W-1:0] t);
    return 32'(t) < NUM_TXNS;
  endfunction

  function automatic logic res_ok(logic [RESOURCE_W-1:0] r);
    return 32'(r) < NUM_RESOURCES;
  endfunction

endpackage

@@ hw/rtl/shared_exclusive_lock_table.sv @@
// ----------------------------------------------------------------------------
// Shared/exclusive lock table
// Lock table with shared holder bitmaps and an exclusive owner per resource.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): cmd, txn, resource. Lock shared or
//   exclusive does a read-modify-write of one table entry; release-all walks
//   every entry and clears the transaction from it.
//   Result channel (out_valid/out_stall): one status per input transaction,
//   in order. The status sits in an output register until taken.
//   Flow: a lock uses its entry read from the RAM in S_LOCK, writes it back
//   if granted and loads its result into the output register, or holds it in
//   S_HOLD while that register is full and stalled. Release-all sweeps one
//   entry per cycle through the RAM port; rejected requests pass through S_HOLD.
//   in_stall is high while an item is in progress, and while the result of
//   the last item cannot enter a full, stalled output register.
//   Reset clears the controller and the per-entry valid bits; an entry never
//   written reads as empty, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_exclusive_lock_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sxlt_pkg::CMD_W-1:0]        in_cmd,
  input  logic [sxlt_pkg::TXN_W-1:0]        in_txn,
  input  logic [sxlt_pkg::RESOURCE_W-1:0]   in_resource,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sxlt_pkg::STATUS_W-1:0]     out_status
);

  sxlt_pkg::state_t state_r, state_nxt;
  sxlt_pkg::cmd_t   cmd_r, cmd_nxt;
  logic [sxlt_pkg::TXN_W-1:0] txn_r, txn_nxt;
  logic [sxlt_pkg::RES_W-1:0] res_r, res_nxt;
  logic [sxlt_pkg::RES_W-1:0] idx_r, idx_nxt;
  logic any_r, any_nxt;
  sxlt_pkg::status_t status_r, status_nxt;

  logic out_valid_r, out_valid_nxt;
  sxlt_pkg::status_t out_status_r, out_status_nxt;

  logic [sxlt_pkg::NUM_RESOURCES-1:0] vld_r, vld_nxt;
  logic rd_vld_r, rd_vld_nxt;

  logic                              rd_en, wr_en;
  logic [sxlt_pkg::RES_W-1:0]        rd_addr, wr_addr;
  logic [sxlt_pkg::ENTRY_W-1:0]      ram_q;
  sxlt_pkg::entry_t                  wr_data;

  sxlt_pkg::entry_t ent, lock_ent, rel_ent;
  logic [sxlt_pkg::NUM_TXNS-1:0] self_mask;
  logic foreign, lock_grant, hit_sh, hit_x, slot_free, load;
  sxlt_pkg::status_t lock_st, sweep_st, load_status;

  sxlt_ram #(
    .WIDTH (sxlt_pkg::ENTRY_W),
    .DEPTH (sxlt_pkg::NUM_RESOURCES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Entry and update logic
  always_comb begin
    ent       = rd_vld_r ? sxlt_pkg::entry_t'(ram_q) : '0;
    self_mask = sxlt_pkg::NUM_TXNS'(1) << txn_r;
    foreign   = ent.excl_valid && (ent.excl_owner != txn_r);

    lock_ent = ent;
    if (cmd_r == sxlt_pkg::CMD_SHARED) begin
      lock_grant       = !foreign;
      lock_ent.sh_bits = ent.sh_bits | self_mask;
    end else begin
      lock_grant          = !foreign && ((ent.sh_bits & ~self_mask) == '0);
      lock_ent.excl_valid = 1'b1;
      lock_ent.excl_owner = txn_r;
    end
    lock_st = lock_grant ? sxlt_pkg::ST_GRANTED : sxlt_pkg::ST_WAIT;

    hit_sh = |(ent.sh_bits & self_mask);
    hit_x  = ent.excl_valid && (ent.excl_owner == txn_r);
    rel_ent         = ent;
    rel_ent.sh_bits = ent.sh_bits & ~self_mask;
    if (hit_x) begin
      rel_ent.excl_valid = 1'b0;
      rel_ent.excl_owner = '0;
    end
    sweep_st = (any_r || hit_sh || hit_x) ? sxlt_pkg::ST_RELEASED : sxlt_pkg::ST_NOTHING;
  end

  // Controller
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    txn_nxt     = txn_r;
    res_nxt     = res_r;
    idx_nxt     = idx_r;
    any_nxt     = any_r;
    status_nxt  = status_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rel_ent;
    load        = 1'b0;
    load_status = status_r;
    slot_free   = !out_valid_r || !out_stall;
    in_stall    = (state_r != sxlt_pkg::S_IDLE);

    unique case (state_r)
      sxlt_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = sxlt_pkg::cmd_t'(in_cmd);
          txn_nxt = in_txn;
          res_nxt = in_resource[sxlt_pkg::RES_W-1:0];
          idx_nxt = '0;
          any_nxt = 1'b0;
          priority if (in_cmd == sxlt_pkg::CMD_RELEASE) begin
            if (sxlt_pkg::txn_ok(in_txn)) begin
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = sxlt_pkg::S_SWEEP;
            end else begin
              status_nxt = sxlt_pkg::ST_NOTHING;
              state_nxt  = sxlt_pkg::S_HOLD;
            end
          end else if (in_cmd != sxlt_pkg::CMD_UNUSED && sxlt_pkg::txn_ok(in_txn)
                       && sxlt_pkg::res_ok(in_resource)) begin
            rd_en     = 1'b1;
            rd_addr   = in_resource[sxlt_pkg::RES_W-1:0];
            state_nxt = sxlt_pkg::S_LOCK;
          end else begin
            status_nxt = sxlt_pkg::ST_WAIT;
            state_nxt  = sxlt_pkg::S_HOLD;
          end
        end
      end
      sxlt_pkg::S_LOCK: begin
        wr_en   = lock_grant;
        wr_addr = res_r;
        wr_data = lock_ent;
        if (slot_free) begin
          load        = 1'b1;
          load_status = lock_st;
          state_nxt   = sxlt_pkg::S_IDLE;
        end else begin
          status_nxt = lock_st;
          state_nxt  = sxlt_pkg::S_HOLD;
        end
      end
      sxlt_pkg::S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rel_ent;
        if (idx_r == sxlt_pkg::RES_W'(sxlt_pkg::NUM_RESOURCES - 1)) begin
          if (slot_free) begin
            load        = 1'b1;
            load_status = sweep_st;
            state_nxt   = sxlt_pkg::S_IDLE;
          end else begin
            status_nxt = sweep_st;
            state_nxt  = sxlt_pkg::S_HOLD;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + sxlt_pkg::RES_W'(1);
          idx_nxt = idx_r + sxlt_pkg::RES_W'(1);
          any_nxt = any_r || hit_sh || hit_x;
        end
      end
      sxlt_pkg::S_HOLD: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = sxlt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sxlt_pkg::S_IDLE;
      end
    endcase

    vld_nxt = vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
    rd_vld_nxt = rd_en ? vld_r[rd_addr] : rd_vld_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    if (load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = load_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sxlt_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      vld_r       <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    txn_r        <= txn_nxt;
    res_r        <= res_nxt;
    idx_r        <= idx_nxt;
    any_r        <= any_nxt;
    status_r     <= status_nxt;
    rd_vld_r     <= rd_vld_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

@@ hw/rtl/sxlt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sxlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/sxlt_checker.sv @@
// ----------------------------------------------------------------------------
// Lock table port checker
// Port-level checks on transaction flow, bound to the lock table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "shared_exclusive_lock_table_defines.svh"

module sxlt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [sxlt_pkg::CMD_W-1:0]        in_cmd,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [sxlt_pkg::STATUS_W-1:0]     out_status
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  `SXLT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status), "stalled result changed")

  `SXLT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall, "input not stalled while busy")

  `SXLT_ASSERT_IMPL(a_unused_waits, clk, rst_n, in_acc && (in_cmd == sxlt_pkg::CMD_UNUSED) && (!out_valid || !out_stall), ##2 (out_valid && (out_status == sxlt_pkg::ST_WAIT)), "unused command not answered with wait")

  `SXLT_ASSERT_IMPL(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result without item in progress")

endmodule

bind shared_exclusive_lock_table sxlt_checker u_sxlt_checker (.*);
